FILE: sv/mdsi_pkg.sv
// ----------------------------------------------------------------------------
// mdsi_pkg - shared types and constants for the drive safety interlock
// Event opcodes, configuration indexes, stream layouts and the step structs.
// ----------------------------------------------------------------------------
package mdsi_pkg;

  typedef enum logic [1:0] {
    OP_UPDATE = 2'd0,
    OP_DRIVE  = 2'd1,
    OP_TICK   = 2'd2,
    OP_ACK    = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    CFG_CLIFF = 2'd0,
    CFG_CUT   = 2'd1,
    CFG_EPOCH = 2'd2,
    CFG_NONE  = 2'd3
  } cfg_idx_e;

  localparam int unsigned InDataW  = 152;
  localparam int unsigned InUserW  = 2;
  localparam int unsigned OutDataW = 40;
  localparam int unsigned CfgDataW = 32;

  localparam logic [63:0]        LinkTimeoutMs = 64'd1000;
  localparam logic [15:0]        MinDurMs      = 16'd50;
  localparam logic [15:0]        MaxDurMs      = 16'd1000;
  localparam logic signed [15:0] SpeedMax      = 16'sd9830;
  localparam logic signed [15:0] SpeedMin      = -16'sd9830;

  typedef struct packed {
    logic        cliff_sensor_present;
    logic        cut_path_present;
    logic [31:0] session_epoch;
  } cfg_t;

  typedef struct packed {
    op_e                opcode;
    logic [63:0]        now_ms;
    logic               link_up;
    logic [31:0]        request_epoch;
    logic signed [15:0] left_speed;
    logic signed [15:0] right_speed;
    logic [15:0]        duration_ms;
    logic [4:0]         hazard_mask;
  } item_t;

  typedef struct packed {
    logic               accepted;
    logic               motor_cut;
    logic               moving;
    logic               latched;
    logic signed [15:0] left_command;
    logic signed [15:0] right_command;
  } res_t;

endpackage

FILE: sv/motor_drive_safety_interlock_top.sv
// ----------------------------------------------------------------------------
// motor_drive_safety_interlock_top - safety interlock for a two-wheel drive
// Takes one event transaction per clock cycle when the result stream is not
// stalled and returns one result transaction for each: the event is first held
// in the input register, then evaluated and the state updated in a single pass
// into the result register. The rate is set by that single-pass step, which
// reads the state left by the previous event in the same cycle. An input
// register and a result register split the two stream sides, so a waiting
// result does not stop the next transaction from being taken. Configuration
// must be written through the plain write port only while the block is idle;
// the block does not enforce this itself. There is no read-back.
// ----------------------------------------------------------------------------
module motor_drive_safety_interlock_top import mdsi_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  // configuration write port
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  // event stream
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // now_ms[63:0], link_up[64], request_epoch[96:65], left_speed[112:97],
  // right_speed[128:113], duration_ms[144:129], hazard_mask[149:145], zero pad
  input  logic [InDataW-1:0]  s_axis_tdata,
  // opcode[1:0]
  input  logic [InUserW-1:0]  s_axis_tuser,
  // result stream
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // accepted[0], motor_cut[1], moving[2], latched[3], left_command[19:4],
  // right_command[35:20], zero pad
  output logic [OutDataW-1:0] m_axis_tdata
);

  cfg_t cfg_q;

  logic               in_valid_q;
  logic [InDataW-1:0] in_data_q;
  logic [InUserW-1:0] in_user_q;
  logic               out_valid_q;
  res_t               out_res_q;

  logic  advance;
  item_t item;
  res_t  res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_CLIFF: cfg_q.cliff_sensor_present <= cfg_data_i[0];
        CFG_CUT:   cfg_q.cut_path_present     <= cfg_data_i[0];
        CFG_EPOCH: cfg_q.session_epoch        <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // advance the held event into the result register when that can take it
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_data_q <= s_axis_tdata;
      in_user_q <= s_axis_tuser;
    end
  end

  assign item = '{
    opcode:        op_e'(in_user_q),
    now_ms:        in_data_q[63:0],
    link_up:       in_data_q[64],
    request_epoch: in_data_q[96:65],
    left_speed:    in_data_q[112:97],
    right_speed:   in_data_q[128:113],
    duration_ms:   in_data_q[144:129],
    hazard_mask:   in_data_q[149:145]
  };

  mdsi_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (advance),
    .item_i (item),
    .cfg_i  (cfg_q),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_res_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'd0, out_res_q.right_command, out_res_q.left_command,
                          out_res_q.latched, out_res_q.moving,
                          out_res_q.motor_cut, out_res_q.accepted};

`ifndef ASSERT_OFF
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_q |-> s_axis_tready)
    else $error("input stalled with result register empty");

  a_advance_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_valid_q)
    else $error("evaluated transaction lost before the result register");

  a_stall_holds_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && out_valid_q && !m_axis_tready) |=> in_valid_q && $stable(in_data_q))
    else $error("held transaction dropped during output stall");
`endif

endmodule

FILE: sv/mdsi_core.sv
// ----------------------------------------------------------------------------
// mdsi_core - interlock state and single-pass event evaluation
// Holds the drive, link and hazard latch state and applies one event per step.
// ----------------------------------------------------------------------------
module mdsi_core import mdsi_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  step_i,
  input  item_t item_i,
  input  cfg_t  cfg_i,
  output res_t  res_o
);

  logic               active_q, active_d;
  logic signed [15:0] left_q, left_d;
  logic signed [15:0] right_q, right_d;
  logic [63:0]        deadline_q, deadline_d;
  logic               link_q, link_d;
  logic [63:0]        last_q, last_d;
  logic               latch_q, latch_d;

  logic [64:0] age;
  logic [64:0] end_sum;
  logic        fresh;
  logic        drive_ok;
  logic        hazard;
  logic        accepted;
  logic        cut;

  always_comb begin
    age      = {1'b0, item_i.now_ms} - {1'b0, last_q};
    // borrow out means the time ran backwards: stale
    fresh    = !age[64] && (age[63:0] <= LinkTimeoutMs);
    end_sum  = {1'b0, item_i.now_ms} + {49'd0, item_i.duration_ms};
    hazard   = |item_i.hazard_mask;
    drive_ok = !latch_q && cfg_i.cliff_sensor_present && cfg_i.cut_path_present &&
               link_q && (item_i.request_epoch == cfg_i.session_epoch) && fresh &&
               (item_i.duration_ms >= MinDurMs) && (item_i.duration_ms <= MaxDurMs) &&
               (item_i.left_speed >= SpeedMin) && (item_i.left_speed <= SpeedMax) &&
               (item_i.right_speed >= SpeedMin) && (item_i.right_speed <= SpeedMax) &&
               !end_sum[64];
  end

  always_comb begin
    active_d   = active_q;
    left_d     = left_q;
    right_d    = right_q;
    deadline_d = deadline_q;
    link_d     = link_q;
    last_d     = last_q;
    latch_d    = latch_q;
    accepted   = 1'b0;
    cut        = 1'b0;
    if (step_i) begin
      case (item_i.opcode)
        OP_UPDATE: begin
          link_d = item_i.link_up;
          last_d = item_i.now_ms;
          if (!item_i.link_up) begin
            cut = 1'b1;
          end
        end
        OP_DRIVE: begin
          if (drive_ok) begin
            left_d     = item_i.left_speed;
            right_d    = item_i.right_speed;
            deadline_d = end_sum[63:0];
            active_d   = (item_i.left_speed != 16'sd0) || (item_i.right_speed != 16'sd0);
            accepted   = 1'b1;
          end
        end
        OP_TICK: begin
          if (hazard) begin
            latch_d = 1'b1;
            cut     = 1'b1;
          end else if (active_q &&
                       (!link_q || !fresh || (item_i.now_ms >= deadline_q))) begin
            cut = 1'b1;
          end
        end
        OP_ACK: begin
          if (!hazard && !active_q) begin
            latch_d = 1'b0;
          end
        end
        default: ;
      endcase
      // a stop clears the whole drive command
      if (cut) begin
        active_d   = 1'b0;
        left_d     = 16'sd0;
        right_d    = 16'sd0;
        deadline_d = 64'd0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q   <= 1'b0;
      left_q     <= 16'sd0;
      right_q    <= 16'sd0;
      deadline_q <= 64'd0;
      link_q     <= 1'b0;
      last_q     <= 64'd0;
      latch_q    <= 1'b0;
    end else begin
      active_q   <= active_d;
      left_q     <= left_d;
      right_q    <= right_d;
      deadline_q <= deadline_d;
      link_q     <= link_d;
      last_q     <= last_d;
      latch_q    <= latch_d;
    end
  end

  assign res_o = '{
    accepted:      accepted,
    motor_cut:     cut,
    moving:        active_d,
    latched:       latch_d,
    left_command:  left_d,
    right_command: right_d
  };

`ifndef ASSERT_OFF
  a_moving_has_speed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    active_q |-> (left_q != 16'sd0) || (right_q != 16'sd0))
    else $error("drive active with both speeds zero");

  a_latch_blocks_drive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    latch_q |-> !active_q)
    else $error("drive active while hazard latch set");

  a_link_down_no_drive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !link_q |-> !active_q)
    else $error("drive active with link down");
`endif

endmodule
